### rtl/core/sbsph_pkg.sv
// ----------------------------------------------------------------------------
// sbsph_pkg
// Shared widths, register indexes, reset values and control types for the
// spectrum band smoother with peak hold.
// ----------------------------------------------------------------------------
package sbsph_pkg;

   // field widths
   localparam int MAG_WIDTH  = 16;
   localparam int IDX_OUT_W  = 6;
   localparam int FRAC_W     = 16;
   localparam int BC_W       = 7;
   localparam int BPB_W      = 11;
   localparam int SCALE_W    = 17;
   localparam int COEF_W     = 16;
   localparam int CSR_DATA_W = 17;
   localparam int CSR_IDX_W  = 3;

   localparam logic [MAG_WIDTH-1:0] MAG_MAX = '1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_BAND_COUNT    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BINS_PER_BAND = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BAND_SCALE    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SMOOTHING     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_DECAY         = 3'd4;

   // register reset values
   localparam logic [BC_W-1:0]    BAND_COUNT_RST    = 7'd32;
   localparam logic [BPB_W-1:0]   BINS_PER_BAND_RST = 11'd16;
   localparam logic [SCALE_W-1:0] BAND_SCALE_RST    = 17'd4096;
   localparam logic [COEF_W-1:0]  SMOOTHING_RST     = 16'd52429;
   localparam logic [COEF_W-1:0]  DECAY_RST         = 16'd62259;

   // unity in Q0.16, one bit wider than a coefficient
   localparam logic [COEF_W:0] Q16_ONE = 17'h10000;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic avg;
      logic mix;
      logic emit;
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic band_done;
      logic out_free;
   } dp_status_type;

endpackage

### rtl/core/sbsph_if.sv
// ----------------------------------------------------------------------------
// sbsph_if
// Valid/ready channels for bin words in and band result words out.
// ----------------------------------------------------------------------------
interface sbsph_req_if import sbsph_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [MAG_WIDTH-1:0] magnitude;
   logic                 frame_start;

   modport source (output valid, magnitude, frame_start, input ready);
   modport sink   (input valid, magnitude, frame_start, output ready);
endinterface

interface sbsph_rsp_if import sbsph_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [IDX_OUT_W-1:0] band_id;
   logic [MAG_WIDTH-1:0] smoothed_level;
   logic [MAG_WIDTH-1:0] hold_level;
   logic                 last_band;

   modport source (output valid, band_id, smoothed_level, hold_level, last_band,
                   input ready);
   modport sink   (input valid, band_id, smoothed_level, hold_level, last_band,
                   output ready);
endinterface

### rtl/core/sbsph_ctrl.sv
// ----------------------------------------------------------------------------
// sbsph_ctrl
// Sequencer: accumulates bins, then steps the band update through average,
// mix and emit, holding off input until the result word is stored.
// ----------------------------------------------------------------------------
module sbsph_ctrl import sbsph_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output ctl_cmd_type   cmd
);

   typedef enum logic [1:0] {
      ST_ACC,
      ST_AVG,
      ST_MIX,
      ST_EMIT
   } state_type;

   state_type state_ff;
   logic      ready_ff;

   // commands decoded from state; accept from the input handshake
   always_comb begin
      cmd.accept = req_valid & ready_ff;
      cmd.avg    = (state_ff == ST_AVG);
      cmd.mix    = (state_ff == ST_MIX);
      cmd.emit   = (state_ff == ST_EMIT);
   end

   assign req_ready = ready_ff;

   // state and registered ready
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ACC;
         ready_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_ACC: begin
               if (cmd.accept && status.band_done) begin
                  state_ff <= ST_AVG;
                  ready_ff <= 1'b0;
               end else begin
                  ready_ff <= 1'b1;
               end
            end
            ST_AVG: begin
               state_ff <= ST_MIX;
            end
            ST_MIX: begin
               state_ff <= ST_EMIT;
            end
            ST_EMIT: begin
               if (status.out_free) begin
                  state_ff <= ST_ACC;
                  ready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff <= ST_ACC;
               ready_ff <= 1'b0;
            end
         endcase
      end
   end

endmodule

### rtl/core/sbsph_datapath.sv
// ----------------------------------------------------------------------------
// sbsph_datapath
// Register file, bin accumulator, per-band stores and the fixed-point
// average, smoothing and peak-hold arithmetic with its output register.
// ----------------------------------------------------------------------------
module sbsph_datapath import sbsph_pkg::*; #(
   parameter int MAX_BANDS = 64,
   parameter int MAX_BINS  = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  logic [MAG_WIDTH-1:0]  magnitude,
   input  logic                  frame_start,
   input  ctl_cmd_type           cmd,
   output dp_status_type         status,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic [IDX_OUT_W-1:0]  band_id,
   output logic [MAG_WIDTH-1:0]  smoothed_level,
   output logic [MAG_WIDTH-1:0]  hold_level,
   output logic                  last_band
);

   localparam int CNT_W  = $clog2(MAX_BINS + 1);
   localparam int BAND_W = $clog2(MAX_BANDS + 1);
   localparam int IDX_W  = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
   localparam int SUM_W  = MAG_WIDTH + $clog2(MAX_BINS);
   localparam int PROD_W = SUM_W + SCALE_W;
   localparam int AVGW_W = PROD_W - FRAC_W;
   localparam int MIX_W  = COEF_W + 1 + MAG_WIDTH;
   localparam int SMIX_W = MIX_W + 1;
   localparam int DEC_W  = MAG_WIDTH + COEF_W;

   // configuration registers
   logic [BC_W-1:0]    band_count_ff;
   logic [BPB_W-1:0]   bins_per_band_ff;
   logic [SCALE_W-1:0] band_scale_ff;
   logic [COEF_W-1:0]  smoothing_ff;
   logic [COEF_W-1:0]  decay_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         band_count_ff    <= BAND_COUNT_RST;
         bins_per_band_ff <= BINS_PER_BAND_RST;
         band_scale_ff    <= BAND_SCALE_RST;
         smoothing_ff     <= SMOOTHING_RST;
         decay_ff         <= DECAY_RST;
      end else if (csr_write) begin
         case (csr_index)
            REG_BAND_COUNT:    band_count_ff    <= csr_data[BC_W-1:0];
            REG_BINS_PER_BAND: bins_per_band_ff <= csr_data[BPB_W-1:0];
            REG_BAND_SCALE:    band_scale_ff    <= csr_data[SCALE_W-1:0];
            REG_SMOOTHING:     smoothing_ff     <= csr_data[COEF_W-1:0];
            REG_DECAY:         decay_ff         <= csr_data[COEF_W-1:0];
            default: ;
         endcase
      end
   end

   // clamped band and bin counts
   logic [BAND_W-1:0] eff_bands;
   logic [CNT_W-1:0]  eff_bins;

   always_comb begin
      if (band_count_ff == '0) begin
         eff_bands = BAND_W'(1);
      end else if (int'(band_count_ff) > MAX_BANDS) begin
         eff_bands = BAND_W'(MAX_BANDS);
      end else begin
         eff_bands = BAND_W'(band_count_ff);
      end
      if (bins_per_band_ff == '0) begin
         eff_bins = CNT_W'(1);
      end else if (int'(bins_per_band_ff) > MAX_BINS) begin
         eff_bins = CNT_W'(MAX_BINS);
      end else begin
         eff_bins = CNT_W'(bins_per_band_ff);
      end
   end

   // accumulator state
   logic [BAND_W-1:0] band_ff;
   logic [CNT_W-1:0]  bin_ff;
   logic [SUM_W-1:0]  sum_ff;

   logic [BAND_W-1:0] base_band;
   logic [CNT_W-1:0]  base_bin;
   logic [SUM_W-1:0]  base_sum;
   logic [CNT_W-1:0]  bin_in;
   logic [SUM_W-1:0]  sum_in;
   logic [BAND_W-1:0] band_in;
   logic              in_frame;
   logic [IDX_W-1:0]  rd_idx;

   // frame start clears before the bin is taken
   always_comb begin
      base_band = frame_start ? '0 : band_ff;
      base_bin  = frame_start ? '0 : bin_ff;
      base_sum  = frame_start ? '0 : sum_ff;
      in_frame  = (base_band < eff_bands);
      bin_in    = base_bin + CNT_W'(1);
      sum_in    = base_sum + SUM_W'(magnitude);
      band_in   = base_band + BAND_W'(1);
      rd_idx    = base_band[IDX_W-1:0];
   end

   assign status.band_done = in_frame && (bin_in >= eff_bins);

   always_ff @(posedge clock) begin
      if (reset) begin
         band_ff <= '0;
         bin_ff  <= '0;
         sum_ff  <= '0;
      end else if (cmd.accept && in_frame) begin
         if (status.band_done) begin
            band_ff <= band_in;
            bin_ff  <= '0;
            sum_ff  <= '0;
         end else begin
            band_ff <= base_band;
            bin_ff  <= bin_in;
            sum_ff  <= sum_in;
         end
      end
   end

   // band under update
   logic [SUM_W-1:0] work_sum_ff;
   logic [IDX_W-1:0] work_band_ff;
   logic             work_last_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept && status.band_done) begin
         work_sum_ff  <= sum_in;
         work_band_ff <= rd_idx;
         work_last_ff <= (band_in == eff_bands);
      end
   end

   // per-band stores, entries read as zero until first written
   logic [MAG_WIDTH-1:0] sm_mem [MAX_BANDS];
   logic [MAG_WIDTH-1:0] pk_mem [MAX_BANDS];
   logic [MAX_BANDS-1:0] ent_valid_ff;
   logic [MAG_WIDTH-1:0] sm_rd_ff;
   logic [MAG_WIDTH-1:0] pk_rd_ff;
   logic                 rd_valid_ff;
   logic [MAG_WIDTH-1:0] prev_sm;
   logic [MAG_WIDTH-1:0] prev_pk;
   logic                 store_wr;
   logic [MAG_WIDTH-1:0] sm_new;
   logic [MAG_WIDTH-1:0] pk_new;

   always_ff @(posedge clock) begin
      if (cmd.accept && status.band_done) begin
         sm_rd_ff    <= sm_mem[rd_idx];
         pk_rd_ff    <= pk_mem[rd_idx];
         rd_valid_ff <= ent_valid_ff[rd_idx];
      end
      if (store_wr) begin
         sm_mem[work_band_ff] <= sm_new;
         pk_mem[work_band_ff] <= pk_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_valid_ff <= '0;
      end else if (store_wr) begin
         ent_valid_ff[work_band_ff] <= 1'b1;
      end
   end

   assign prev_sm = rd_valid_ff ? sm_rd_ff : '0;
   assign prev_pk = rd_valid_ff ? pk_rd_ff : '0;

   // average with saturation, and the decayed peak
   logic [PROD_W-1:0]    avg_prod;
   logic [AVGW_W-1:0]    avg_wide;
   logic [DEC_W-1:0]     dec_prod;
   logic [MAG_WIDTH-1:0] avg_ff;
   logic [MAG_WIDTH-1:0] dec_ff;

   always_comb begin
      avg_prod = PROD_W'(work_sum_ff) * PROD_W'(band_scale_ff);
      avg_wide = avg_prod[PROD_W-1:FRAC_W];
      dec_prod = DEC_W'(prev_pk) * DEC_W'(decay_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.avg) begin
         avg_ff <= (avg_wide > AVGW_W'(MAG_MAX)) ? MAG_MAX : avg_wide[MAG_WIDTH-1:0];
         dec_ff <= dec_prod[FRAC_W +: MAG_WIDTH];
      end
   end

   // smoothing products: new weight times average, old weight times previous
   logic [COEF_W:0]  new_weight;
   logic [MIX_W-1:0] mix_a_ff;
   logic [MIX_W-1:0] mix_b_ff;

   assign new_weight = Q16_ONE - {1'b0, smoothing_ff};

   always_ff @(posedge clock) begin
      if (cmd.mix) begin
         mix_a_ff <= MIX_W'(new_weight) * MIX_W'(avg_ff);
         mix_b_ff <= MIX_W'(smoothing_ff) * MIX_W'(prev_sm);
      end
   end

   // final sum, peak select and store write-back
   logic [SMIX_W-1:0] mix_sum;

   always_comb begin
      mix_sum = SMIX_W'(mix_a_ff) + SMIX_W'(mix_b_ff);
      sm_new  = mix_sum[FRAC_W +: MAG_WIDTH];
      pk_new  = (sm_new > prev_pk) ? sm_new : dec_ff;
   end

   // output register
   logic out_valid_ff;

   assign status.out_free = !out_valid_ff || rsp_ready;
   assign store_wr        = cmd.emit && status.out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (store_wr) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (store_wr) begin
         band_id        <= IDX_OUT_W'(work_band_ff);
         smoothed_level <= sm_new;
         hold_level     <= pk_new;
         last_band      <= work_last_ff;
      end
   end

   assign rsp_valid = out_valid_ff;

endmodule

### rtl/core/spectrum_band_smooth_peak_hold.sv
// ----------------------------------------------------------------------------
// spectrum_band_smooth_peak_hold
// Groups FFT magnitude bins into equal bands, averages each band, and keeps
// a per-band smoothed level and a decaying peak-hold level.
//
//   channel | direction | handshake         | word
//   req_bus | in        | valid/ready       | magnitude, frame_start
//   rsp_bus | out       | valid/ready       | band_id, smoothed_level,
//           |           |                   | hold_level, last_band
//   csr_*   | in        | write enable only | register index, data
//
// A bin that does not close a band only adds to the running sum, and input
// stays ready. A bin that closes a band is taken with a read of the band
// stores, then steps through the averaging multiply, the smoothing products
// and the write-back that loads the output register. The last step waits
// while a previous band word is still held in the output register. Reset is
// synchronous; no clearing pass is needed, the stores are valid-bit tracked.
// ----------------------------------------------------------------------------
module spectrum_band_smooth_peak_hold import sbsph_pkg::*; #(
   parameter int MAX_BANDS = 64,
   parameter int MAX_BINS  = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   sbsph_req_if.sink             req_bus,
   sbsph_rsp_if.source           rsp_bus
);

   ctl_cmd_type   cmd;
   dp_status_type status;

   // sequencer
   sbsph_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // arithmetic and storage
   sbsph_datapath #(
      .MAX_BANDS (MAX_BANDS),
      .MAX_BINS  (MAX_BINS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .magnitude      (req_bus.magnitude),
      .frame_start    (req_bus.frame_start),
      .cmd            (cmd),
      .status         (status),
      .rsp_ready      (rsp_bus.ready),
      .rsp_valid      (rsp_bus.valid),
      .band_id        (rsp_bus.band_id),
      .smoothed_level (rsp_bus.smoothed_level),
      .hold_level     (rsp_bus.hold_level),
      .last_band      (rsp_bus.last_band)
   );

endmodule

### rtl/core/sbsph_checker.sv
// ----------------------------------------------------------------------------
// sbsph_checker
// Port-level checks on the band smoother: output hold under stall, reset
// behaviour and the spacing between a closing bin and its band word.
// ----------------------------------------------------------------------------
module sbsph_checker import sbsph_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [IDX_OUT_W-1:0] rsp_band_id,
   input logic [MAG_WIDTH-1:0] rsp_smoothed_level,
   input logic [MAG_WIDTH-1:0] rsp_hold_level,
   input logic                 rsp_last_band
);

   logic req_acc;

   assign req_acc = req_valid && req_ready;

   // a held band word stays until taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("band word dropped while stalled");

   // a held band word does not change
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_band_id) && $stable(rsp_smoothed_level)
         && $stable(rsp_hold_level) && $stable(rsp_last_band))
      else $error("band word changed while stalled");

   // reset empties the output register and blocks input
   assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_ready)
      else $error("output or input live after reset");

   // no bins are taken while a band update runs
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_acc, 1) && !$past(req_acc, 2) && !$past(req_acc, 3))
      else $error("bin taken during band update");

endmodule

bind spectrum_band_smooth_peak_hold sbsph_checker u_sbsph_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_bus.valid),
   .req_ready          (req_bus.ready),
   .rsp_valid          (rsp_bus.valid),
   .rsp_ready          (rsp_bus.ready),
   .rsp_band_id        (rsp_bus.band_id),
   .rsp_smoothed_level (rsp_bus.smoothed_level),
   .rsp_hold_level     (rsp_bus.hold_level),
   .rsp_last_band      (rsp_bus.last_band)
);
